[rtl/euler_vector_rotation_unit_defines.svh]
// Assertion macros for the Euler vector rotation unit
`ifndef EULER_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define EULER_VECTOR_ROTATION_UNIT_DEFINES_SVH

// assert that an antecedent implies a consequent on the same edge
`define EVR_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// assert that an antecedent implies a consequent on the next edge
`define EVR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/evr_pkg.sv]
// Package for the Euler vector rotation unit: constants, types, CORDIC table
package evr_pkg;

    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int COEFF_FRAC_BITS_DEF = 16;
    localparam int ANGLE_WIDTH         = 16;
    localparam int CORDIC_STAGES       = 18;
    localparam int CORDIC_W            = 34;   // Q2.30 plus guard bits
    localparam int ZW                  = 34;   // angle residual, 2^-32 turn units
    localparam int STAGE_W             = 5;
    localparam int NUM_COEFFS          = 9;
    localparam int CFG_ADDR_W          = 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [CFG_ADDR_W-1:0] REG_ROLL  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PITCH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_YAW   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIG,
        ST_MAT,
        ST_ROT,
        ST_OUT
    } state_t;

    // lane status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

    function automatic logic signed [ZW-1:0] atan_turn(input logic [STAGE_W-1:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:  r = 34'sd536870912;
            5'd1:  r = 34'sd316933406;
            5'd2:  r = 34'sd167458907;
            5'd3:  r = 34'sd85004756;
            5'd4:  r = 34'sd42667331;
            5'd5:  r = 34'sd21354465;
            5'd6:  r = 34'sd10679838;
            5'd7:  r = 34'sd5340245;
            5'd8:  r = 34'sd2670163;
            5'd9:  r = 34'sd1335087;
            5'd10: r = 34'sd667544;
            5'd11: r = 34'sd333772;
            5'd12: r = 34'sd166886;
            5'd13: r = 34'sd83443;
            5'd14: r = 34'sd41722;
            5'd15: r = 34'sd20861;
            5'd16: r = 34'sd10430;
            5'd17: r = 34'sd5215;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/euler_vector_rotation_unit.sv]
// Top level of the Euler vector rotation unit: control, coefficient store, output register
//
//  Channel | Dir  | Beat contents
//  s_axis  | in   | tdata: vec_x, vec_y, vec_z
//  m_axis  | out  | tdata: out_x, out_y, out_z; tuser: clipped
//  cfg     | in   | cfg_wr_en, cfg_addr, cfg_wdata (roll, pitch, yaw)
//
// One beat at a time. With a current matrix a beat runs through the accept
// cycle, the rotation steps (nine products through the shared multiplier plus
// pipeline fill) and a hand-off cycle into the output register.
// After a register write the next beat first runs three CORDIC lanes in
// parallel (18 stages, one per cycle) and 12 products for the matrix before
// its rotation. Reset loads identity; a result still held in the output
// register stalls the next beat in its hand-off cycle.
`include "euler_vector_rotation_unit_defines.svh"
module euler_vector_rotation_unit #(
    parameter int SAMPLE_WIDTH    = evr_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = evr_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  s_axis_tdata,  // vec_x, vec_y, vec_z
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,  // out_x, out_y, out_z
    output logic                                 m_axis_tuser,  // clipped
    input  logic                                 cfg_wr_en,
    input  logic [evr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [evr_pkg::ANGLE_WIDTH-1:0]      cfg_wdata
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = COEFF_FRAC_BITS + 2;
    localparam int BW = (SW > CW ? SW : CW) + 1;
    localparam int AW = SW + CW + 4;
    localparam int DW = ((3*SW+7)/8)*8;
    localparam logic signed [CW-1:0] ONE = CW'(1) <<< COEFF_FRAC_BITS;
    localparam int TW = 13;   // last matrix sequence step
    localparam int SEQ_W = 5;

    logic signed [evr_pkg::ANGLE_WIDTH-1:0] roll_reg, pitch_reg, yaw_reg;
    logic stale_reg;
    logic signed [CW-1:0] coef_reg [evr_pkg::NUM_COEFFS];
    logic signed [CW-1:0] tmp_reg [4];  // czcx szcx czsx szsx
    logic signed [SW-1:0] vin_reg [3];
    logic [DW-1:0] wdata_reg, mdata_reg;
    logic wclip_reg;
    logic mvalid_reg, mclip_reg;
    evr_pkg::state_t state_reg, state_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;

    logic signed [CW-1:0] sx, cx, sy, cy, sz, cz;
    evr_pkg::lane_stat_t st_r, st_p, st_y;
    logic trig_start;

    logic signed [CW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic acc_clr, acc_en;
    logic signed [AW-1:0] acc_q;
    logic signed [CW-1:0] prod_q;

    logic s_fire, m_fire, out_free;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = mvalid_reg && m_axis_tready;
    assign out_free = !mvalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == evr_pkg::ST_IDLE);

    // three CORDIC lanes, one per angle
    evr_cordic #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_r (
        .aclk, .aresetn, .start(trig_start), .angle(roll_reg),
        .stat(st_r), .sin_q(sx), .cos_q(cx));
    evr_cordic #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_p (
        .aclk, .aresetn, .start(trig_start), .angle(pitch_reg),
        .stat(st_p), .sin_q(sy), .cos_q(cy));
    evr_cordic #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_lane_y (
        .aclk, .aresetn, .start(trig_start), .angle(yaw_reg),
        .stat(st_y), .sin_q(sz), .cos_q(cz));

    evr_mac #(.SAMPLE_WIDTH(SW), .COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_mac (
        .aclk, .mul_a, .mul_b, .acc_clr, .acc_en, .acc_q, .prod_q);

    // next state
    always_comb begin
        state_next = state_reg;
        seq_next   = seq_reg;
        unique case (state_reg)
            evr_pkg::ST_IDLE: if (s_fire) begin
                state_next = stale_reg ? evr_pkg::ST_TRIG : evr_pkg::ST_ROT;
                seq_next   = '0;
            end
            evr_pkg::ST_TRIG: if (st_r.done) begin
                state_next = evr_pkg::ST_MAT;
                seq_next   = '0;
            end
            // 12 products issued at seq 0..11, result at seq+1
            evr_pkg::ST_MAT: begin
                seq_next = seq_reg + 1'b1;
                if (seq_reg == SEQ_W'(TW)) begin
                    state_next = evr_pkg::ST_ROT;
                    seq_next   = '0;
                end
            end
            // 9 products issued at seq 0..8, accumulated at seq+1
            evr_pkg::ST_ROT: begin
                seq_next = seq_reg + 1'b1;
                if (seq_reg == SEQ_W'(11)) state_next = evr_pkg::ST_OUT;
            end
            // wait here while the previous result is still held
            evr_pkg::ST_OUT: if (out_free) state_next = evr_pkg::ST_IDLE;
            default: state_next = evr_pkg::ST_IDLE;
        endcase
    end

    // operand selection
    logic signed [CW-1:0] op_a, op_b;
    logic [1:0] col;
    logic [1:0] row_sel;
    always_comb begin
        op_a = '0; op_b = '0;
        mul_a = '0; mul_b = '0;
        acc_clr = 1'b0; acc_en = 1'b0;
        trig_start = (state_reg == evr_pkg::ST_IDLE) && s_fire && stale_reg;
        col = '0; row_sel = '0;
        unique case (state_reg)
            evr_pkg::ST_MAT: begin
                case (seq_reg)
                    5'd0:  begin op_a = cz;         op_b = cx; end
                    5'd1:  begin op_a = sz;         op_b = cx; end
                    5'd2:  begin op_a = sx;         op_b = cz; end
                    5'd3:  begin op_a = sx;         op_b = sz; end
                    5'd4:  begin op_a = cz;         op_b = cy; end
                    5'd5:  begin op_a = cy;         op_b = sz; end
                    5'd6:  begin op_a = sx;         op_b = cy; end
                    5'd7:  begin op_a = cy;         op_b = cx; end
                    5'd8:  begin op_a = tmp_reg[2]; op_b = sy; end
                    5'd9:  begin op_a = tmp_reg[3]; op_b = sy; end
                    5'd10: begin op_a = tmp_reg[0]; op_b = sy; end
                    5'd11: begin op_a = tmp_reg[1]; op_b = sy; end
                    default: ;
                endcase
                mul_a = op_a;
                mul_b = BW'(op_b);
            end
            evr_pkg::ST_ROT: begin
                // out_j = c[j]*x + c[3+j]*y + c[6+j]*z; seq = 3*j + k
                case (seq_reg) inside
                    5'd0, 5'd1, 5'd2: col = 2'd0;
                    5'd3, 5'd4, 5'd5: col = 2'd1;
                    5'd6, 5'd7, 5'd8: col = 2'd2;
                    default: ;
                endcase
                case (seq_reg) inside
                    5'd0, 5'd3, 5'd6: row_sel = 2'd0;
                    5'd1, 5'd4, 5'd7: row_sel = 2'd1;
                    5'd2, 5'd5, 5'd8: row_sel = 2'd2;
                    default: ;
                endcase
                if (seq_reg < 5'd9) begin
                    mul_a = coef_reg[4'(row_sel) * 4'd3 + 4'(col)];
                    mul_b = BW'(vin_reg[row_sel]);
                end
                // each column sum opens with its first product
                acc_clr = (seq_reg == 5'd1) || (seq_reg == 5'd4) || (seq_reg == 5'd7);
                acc_en  = (seq_reg >= 5'd1) && (seq_reg <= 5'd9);
            end
            default: ;
        endcase
    end

    // saturation of a finished dot product
    localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (SW - 1)) - 1);
    localparam logic signed [AW-1:0] LO = -HI - 1;
    logic signed [AW-1:0] rnd;
    logic [SW-1:0] sat;
    logic sat_hit;
    always_comb begin
        rnd = (acc_q + (AW'(1) <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
        sat_hit = 1'b0;
        sat = SW'(rnd);
        if (rnd > HI) begin sat = SW'(HI); sat_hit = 1'b1; end
        else if (rnd < LO) begin sat = SW'(LO); sat_hit = 1'b1; end
    end

    function automatic logic signed [CW-1:0] clampc(input logic signed [CW:0] v);
        logic signed [CW:0] one;
        one = (CW+1)'(ONE);
        if (v > one) return ONE;
        if (v < -one) return -ONE;
        return CW'(v);
    endfunction

    // accumulator holds a finished column at these steps
    logic [1:0] res_col;
    logic res_hit;
    always_comb begin
        res_col = 2'd0;
        res_hit = 1'b0;
        case (seq_reg)
            5'd4:  begin res_col = 2'd0; res_hit = 1'b1; end
            5'd7:  begin res_col = 2'd1; res_hit = 1'b1; end
            5'd10: begin res_col = 2'd2; res_hit = 1'b1; end
            default: ;
        endcase
    end

    // clocked state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= evr_pkg::ST_IDLE;
            seq_reg    <= '0;
            stale_reg  <= 1'b0;
            roll_reg   <= '0;
            pitch_reg  <= '0;
            yaw_reg    <= '0;
            mvalid_reg <= 1'b0;
            for (int k = 0; k < evr_pkg::NUM_COEFFS; k++)
                coef_reg[k] <= (k % 4 == 0) ? ONE : '0;
        end else begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    evr_pkg::REG_ROLL:  begin roll_reg  <= cfg_wdata; stale_reg <= 1'b1; end
                    evr_pkg::REG_PITCH: begin pitch_reg <= cfg_wdata; stale_reg <= 1'b1; end
                    evr_pkg::REG_YAW:   begin yaw_reg   <= cfg_wdata; stale_reg <= 1'b1; end
                    default: ;
                endcase
            end
            if (state_reg == evr_pkg::ST_TRIG && st_r.done) begin
                stale_reg   <= 1'b0;
                coef_reg[2] <= sy;
            end
            if (state_reg == evr_pkg::ST_MAT) begin
                case (seq_reg)
                    5'd1:  tmp_reg[0] <= prod_q;
                    5'd2:  tmp_reg[1] <= prod_q;
                    5'd3:  tmp_reg[2] <= prod_q;
                    5'd4:  tmp_reg[3] <= prod_q;
                    5'd5:  coef_reg[0] <= prod_q;
                    5'd6:  coef_reg[1] <= clampc(-(CW+1)'(prod_q));
                    5'd7:  coef_reg[5] <= clampc(-(CW+1)'(prod_q));
                    5'd8:  coef_reg[8] <= prod_q;
                    5'd9:  coef_reg[3] <= clampc((CW+1)'(tmp_reg[1]) + (CW+1)'(prod_q));
                    5'd10: coef_reg[4] <= clampc((CW+1)'(tmp_reg[0]) - (CW+1)'(prod_q));
                    5'd11: coef_reg[6] <= clampc((CW+1)'(tmp_reg[3]) - (CW+1)'(prod_q));
                    5'd12: coef_reg[7] <= clampc((CW+1)'(tmp_reg[2]) + (CW+1)'(prod_q));
                    default: ;
                endcase
            end
            if (state_reg == evr_pkg::ST_OUT && out_free) mvalid_reg <= 1'b1;
            else if (m_fire) mvalid_reg <= 1'b0;
        end
        if (s_fire) begin
            vin_reg[0] <= s_axis_tdata[0 +: SW];
            vin_reg[1] <= s_axis_tdata[SW +: SW];
            vin_reg[2] <= s_axis_tdata[2*SW +: SW];
            wclip_reg  <= 1'b0;
            wdata_reg  <= '0;
        end
        if (state_reg == evr_pkg::ST_ROT && res_hit) begin
            wdata_reg[SW*res_col +: SW] <= sat;
            if (sat_hit) wclip_reg <= 1'b1;
        end
        if (state_reg == evr_pkg::ST_OUT && out_free) begin
            mdata_reg <= wdata_reg;
            mclip_reg <= wclip_reg;
        end
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;
    assign m_axis_tuser  = mclip_reg;

    `EVR_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != evr_pkg::ST_IDLE, !s_axis_tready, "input accepted while busy")
    `EVR_ASSERT_NEXT(a_out_after_rot, aclk, aresetn, state_reg == evr_pkg::ST_OUT, m_axis_tvalid, "result lost after rotation")
    `EVR_ASSERT_IMPL(a_lanes_lockstep, aclk, aresetn, 1'b1, st_p == st_r && st_y == st_r, "CORDIC lanes out of step")
endmodule

[rtl/evr_cordic.sv]
// Iterative CORDIC lane: sine and cosine of one binary angle, one stage per cycle
module evr_cordic #(
    parameter int COEFF_FRAC_BITS = evr_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CW = COEFF_FRAC_BITS + 2
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle,
    output evr_pkg::lane_stat_t                   stat,
    output logic signed [CW-1:0]                  sin_q,
    output logic signed [CW-1:0]                  cos_q
);
    localparam int W  = evr_pkg::CORDIC_W;
    localparam int SH = 30 - COEFF_FRAC_BITS;
    localparam logic signed [W-1:0] ONE = W'(1) <<< COEFF_FRAC_BITS;

    logic signed [W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [evr_pkg::ZW-1:0] z_reg, z_next;
    logic [evr_pkg::STAGE_W-1:0] i_reg, i_next;
    logic busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic signed [evr_pkg::ANGLE_WIDTH:0] a_fold;
    logic fold;
    logic signed [W-1:0] xf, yf, xr, yr;

    always_comb begin
        fold   = 1'b0;
        a_fold = {angle[evr_pkg::ANGLE_WIDTH-1], angle};
        if (angle > 16'sd16384) begin
            a_fold = a_fold - 17'sd32768;
            fold   = 1'b1;
        end else if (angle < -16'sd16384) begin
            a_fold = a_fold + 17'sd32768;
            fold   = 1'b1;
        end
    end

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg; done_next = 1'b0; flip_next = flip_reg;
        if (start) begin
            x_next = evr_pkg::CORDIC_GAIN;
            y_next = '0;
            z_next = evr_pkg::ZW'(a_fold) <<< 16;
            i_next = '0;
            flip_next = fold;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - (y_reg >>> i_reg);
                y_next = y_reg + (x_reg >>> i_reg);
                z_next = z_reg - evr_pkg::atan_turn(i_reg);
            end else begin
                x_next = x_reg + (y_reg >>> i_reg);
                y_next = y_reg - (x_reg >>> i_reg);
                z_next = z_reg + evr_pkg::atan_turn(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == evr_pkg::STAGE_W'(evr_pkg::CORDIC_STAGES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; flip_reg <= flip_next;
    end

    // undo fold, round half up, clamp to [-1, 1]
    always_comb begin
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        if (SH > 0) begin
            xr = (xf + (W'(1) <<< (SH - 1))) >>> SH;
            yr = (yf + (W'(1) <<< (SH - 1))) >>> SH;
        end else begin
            xr = xf;
            yr = yf;
        end
        if (xr > ONE) xr = ONE; else if (xr < -ONE) xr = -ONE;
        if (yr > ONE) yr = ONE; else if (yr < -ONE) yr = -ONE;
    end

    assign cos_q = CW'(xr);
    assign sin_q = CW'(yr);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
endmodule

[rtl/evr_mac.sv]
// Shared multiply-accumulate datapath: matrix build products and the rotation dot products
module evr_mac #(
    parameter int SAMPLE_WIDTH    = evr_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = evr_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CW = COEFF_FRAC_BITS + 2
) (
    input  logic                          aclk,
    input  logic signed [CW-1:0]          mul_a,
    input  logic signed [(SAMPLE_WIDTH > CW ? SAMPLE_WIDTH : CW):0] mul_b,
    input  logic                          acc_clr,
    input  logic                          acc_en,
    output logic signed [SAMPLE_WIDTH + CW + 3:0] acc_q,
    output logic signed [CW-1:0]          prod_q
);
    localparam int BW = (SAMPLE_WIDTH > CW ? SAMPLE_WIDTH : CW) + 1;
    localparam int PW = CW + BW;
    localparam int AW = SAMPLE_WIDTH + CW + 4;

    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [PW-1:0] pr;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        // acc_clr opens a new sum with the registered product
        if (acc_clr)     acc_reg <= AW'(prod_reg);
        else if (acc_en) acc_reg <= acc_reg + AW'(prod_reg);
    end

    // Q product rounded half up back to coefficient format
    assign pr     = (prod_reg + (PW'(1) <<< (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
    assign prod_q = CW'(pr);
    assign acc_q  = acc_reg;
endmodule
